// ===== sv/wtcq_pkg.sv =====
// Shared types, constants and functions for the WMM transmit class queue scheduler.
`timescale 1ns / 1ps
package wtcq_pkg;

   localparam int unsigned HANDLE_W    = 8;
   localparam int unsigned PRIO_W      = 3;
   localparam int unsigned CLASS_W     = 2;
   localparam int unsigned NUM_CLASSES = 4;

   localparam int unsigned DEF_VOICE_DEPTH       = 16;
   localparam int unsigned DEF_VIDEO_DEPTH       = 16;
   localparam int unsigned DEF_BEST_EFFORT_DEPTH = 16;
   localparam int unsigned DEF_BACKGROUND_DEPTH  = 16;

   // handles at or above this are not valid buffers
   localparam int unsigned POOL_SIZE = 256;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   localparam logic [CLASS_W-1:0] CLASS_VO = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_VI = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_BE = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_BG = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } wtcq_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic capture_handle;
   } wtcq_cmd_type;

   typedef struct packed {
      logic deq_hit;
   } wtcq_status_type;

   function automatic logic [CLASS_W-1:0] prio_to_class(input logic [PRIO_W-1:0] prio);
      logic [CLASS_W-1:0] cls;
      case (prio) inside
         3'd7, 3'd6: cls = CLASS_VO;
         3'd5, 3'd4: cls = CLASS_VI;
         3'd2, 3'd1: cls = CLASS_BG;
         default:    cls = CLASS_BE;
      endcase
      return cls;
   endfunction

endpackage

// ===== sv/wtcq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wtcq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wtcq_ctrl.sv =====
// Sequencer: accept, execute, optional storage read, present result.
`timescale 1ns / 1ps
module wtcq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wtcq_pkg::wtcq_cmd_type    cmd,
   input  wtcq_pkg::wtcq_status_type status
);
   import wtcq_pkg::*;

   wtcq_state_type state_ff;
   wtcq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.deq_hit ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            cmd.capture_handle = 1'b1;
            state_in           = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/wtcq_dp.sv =====
// Datapath: per-class queue pointers and storage, priority pick, result register.
`timescale 1ns / 1ps
module wtcq_dp #(
   parameter int unsigned VOICE_DEPTH       = wtcq_pkg::DEF_VOICE_DEPTH,
   parameter int unsigned VIDEO_DEPTH       = wtcq_pkg::DEF_VIDEO_DEPTH,
   parameter int unsigned BEST_EFFORT_DEPTH = wtcq_pkg::DEF_BEST_EFFORT_DEPTH,
   parameter int unsigned BACKGROUND_DEPTH  = wtcq_pkg::DEF_BACKGROUND_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_action,
   input  logic [wtcq_pkg::PRIO_W-1:0]        req_user_priority,
   input  logic [wtcq_pkg::HANDLE_W-1:0]      req_packet_handle,
   input  logic [wtcq_pkg::NUM_CLASSES-1:0]   req_downstream_ready,
   input  wtcq_pkg::wtcq_cmd_type             cmd,
   output wtcq_pkg::wtcq_status_type          status,
   output logic                               rsp_handed_back,
   output logic                               rsp_tx_valid,
   output logic [wtcq_pkg::HANDLE_W-1:0]      rsp_tx_handle,
   output logic [wtcq_pkg::CLASS_W-1:0]       rsp_tx_class,
   output logic                               rsp_more_pending
);
   import wtcq_pkg::*;

   localparam int unsigned DEPTHS [NUM_CLASSES] = '{
      VOICE_DEPTH, VIDEO_DEPTH, BEST_EFFORT_DEPTH, BACKGROUND_DEPTH
   };

   // captured transaction
   logic                   action_ff;
   logic [PRIO_W-1:0]      prio_ff;
   logic [HANDLE_W-1:0]    handle_ff;
   logic [NUM_CLASSES-1:0] ready_ff;

   // result register
   logic                   handed_back_ff, handed_back_in;
   logic                   tx_valid_ff, tx_valid_in;
   logic [HANDLE_W-1:0]    tx_handle_ff, tx_handle_in;
   logic [CLASS_W-1:0]     tx_class_ff, tx_class_in;
   logic                   more_ff, more_in;

   logic [NUM_CLASSES-1:0] full;
   logic [NUM_CLASSES-1:0] nonempty;
   logic [NUM_CLASSES-1:0] multi;
   logic [NUM_CLASSES-1:0] push;
   logic [NUM_CLASSES-1:0] pop;
   logic [HANDLE_W-1:0]    rdata [NUM_CLASSES];

   logic [CLASS_W-1:0]     enq_class;
   logic                   enq_reject;
   logic [NUM_CLASSES-1:0] eligible;
   logic [NUM_CLASSES-1:0] pick_oh;
   logic [CLASS_W-1:0]     pick_class;
   logic                   pick_hit;
   logic [NUM_CLASSES-1:0] left_after;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         prio_ff   <= req_user_priority;
         handle_ff <= req_packet_handle;
         ready_ff  <= req_downstream_ready;
      end
   end

   assign enq_class  = prio_to_class(prio_ff);
   assign enq_reject = ({1'b0, handle_ff} >= (HANDLE_W + 1)'(POOL_SIZE)) || full[enq_class];

   assign eligible = ready_ff & nonempty;

   always_comb begin
      pick_oh    = '0;
      pick_class = CLASS_VO;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (eligible[i]) begin
            pick_oh    = '0;
            pick_oh[i] = 1'b1;
            pick_class = CLASS_W'(i);
         end
      end
   end

   assign pick_hit   = |eligible;
   assign left_after = (nonempty & ~pick_oh) | (multi & pick_oh);

   assign status.deq_hit = (action_ff == ACT_DEQUEUE) && pick_hit;

   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         push[i] = cmd.exec && (action_ff == ACT_ENQUEUE) && !enq_reject &&
                   (enq_class == CLASS_W'(i));
         pop[i]  = cmd.exec && status.deq_hit && pick_oh[i];
      end
   end

   always_comb begin
      handed_back_in = handed_back_ff;
      tx_valid_in    = tx_valid_ff;
      tx_handle_in   = tx_handle_ff;
      tx_class_in    = tx_class_ff;
      more_in        = more_ff;
      if (cmd.exec) begin
         handed_back_in = 1'b0;
         tx_valid_in    = 1'b0;
         tx_handle_in   = '0;
         tx_class_in    = CLASS_VO;
         more_in        = 1'b0;
         if (action_ff == ACT_ENQUEUE) begin
            handed_back_in = enq_reject;
            tx_class_in    = enq_class;
         end else if (pick_hit) begin
            tx_valid_in = 1'b1;
            tx_class_in = pick_class;
            more_in     = |(ready_ff & left_after);
         end
      end else if (cmd.capture_handle) begin
         tx_handle_in = rdata[tx_class_ff];
      end
   end

   always_ff @(posedge clock) begin
      handed_back_ff <= handed_back_in;
      tx_valid_ff    <= tx_valid_in;
      tx_handle_ff   <= tx_handle_in;
      tx_class_ff    <= tx_class_in;
      more_ff        <= more_in;
   end

   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_class
      localparam int unsigned D  = DEPTHS[g];
      localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
      localparam int unsigned CW = $clog2(D + 1);
      localparam int unsigned SW = $clog2(2 * D);

      logic [CW-1:0] count_ff, count_in;
      logic [PW-1:0] rd_ff, rd_in;
      logic [SW-1:0] wr_sum;
      logic [SW-1:0] wr_wrap;

      assign full[g]     = (count_ff == CW'(D));
      assign nonempty[g] = (count_ff != '0);
      assign multi[g]    = (count_ff > CW'(1));

      assign wr_sum  = SW'(rd_ff) + SW'(count_ff);
      assign wr_wrap = (wr_sum >= SW'(D)) ? (wr_sum - SW'(D)) : wr_sum;

      always_comb begin
         count_in = count_ff;
         rd_in    = rd_ff;
         if (push[g]) begin
            count_in = count_ff + CW'(1);
         end else if (pop[g]) begin
            count_in = count_ff - CW'(1);
            rd_in    = (rd_ff == PW'(D - 1)) ? '0 : rd_ff + PW'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff <= '0;
            rd_ff    <= '0;
         end else begin
            count_ff <= count_in;
            rd_ff    <= rd_in;
         end
      end

      wtcq_ram #(
         .WIDTH (HANDLE_W),
         .DEPTH (D)
      ) u_store (
         .clock   (clock),
         .wr_en   (push[g]),
         .wr_addr (wr_wrap[PW-1:0]),
         .wr_data (handle_ff),
         .rd_en   (pop[g]),
         .rd_addr (rd_ff),
         .rd_data (rdata[g])
      );
   end

   assign rsp_handed_back  = handed_back_ff;
   assign rsp_tx_valid     = tx_valid_ff;
   assign rsp_tx_handle    = tx_handle_ff;
   assign rsp_tx_class     = tx_class_ff;
   assign rsp_more_pending = more_ff;

endmodule

// ===== sv/wmm_tx_class_queue_scheduler.sv =====
// Top level of the WMM transmit class queue scheduler.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  action, user_priority, packet_handle,
//                                             downstream_ready
//   rsp_      out        rsp_valid/rsp_stall  handed_back, tx_valid, tx_handle,
//                                             tx_class, more_pending
//
// One transaction at a time. Enqueue: the sequencer goes from accept to execute to
// result. Dequeue that pops: a registered storage read sits between execute and
// result. Rate is set by the single-issue sequencer.
// Synchronous reset empties all queues at once; storage contents are left as is.
// rsp_stall holds the result and keeps req_stall high until it is taken.
`timescale 1ns / 1ps
module wmm_tx_class_queue_scheduler #(
   parameter int unsigned VOICE_DEPTH       = wtcq_pkg::DEF_VOICE_DEPTH,
   parameter int unsigned VIDEO_DEPTH       = wtcq_pkg::DEF_VIDEO_DEPTH,
   parameter int unsigned BEST_EFFORT_DEPTH = wtcq_pkg::DEF_BEST_EFFORT_DEPTH,
   parameter int unsigned BACKGROUND_DEPTH  = wtcq_pkg::DEF_BACKGROUND_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [wtcq_pkg::PRIO_W-1:0]       req_user_priority,
   input  logic [wtcq_pkg::HANDLE_W-1:0]     req_packet_handle,
   input  logic [wtcq_pkg::NUM_CLASSES-1:0]  req_downstream_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_handed_back,
   output logic                              rsp_tx_valid,
   output logic [wtcq_pkg::HANDLE_W-1:0]     rsp_tx_handle,
   output logic [wtcq_pkg::CLASS_W-1:0]      rsp_tx_class,
   output logic                              rsp_more_pending
);
   import wtcq_pkg::*;

   wtcq_cmd_type    cmd;
   wtcq_status_type status;

   wtcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   wtcq_dp #(
      .VOICE_DEPTH       (VOICE_DEPTH),
      .VIDEO_DEPTH       (VIDEO_DEPTH),
      .BEST_EFFORT_DEPTH (BEST_EFFORT_DEPTH),
      .BACKGROUND_DEPTH  (BACKGROUND_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_action           (req_action),
      .req_user_priority    (req_user_priority),
      .req_packet_handle    (req_packet_handle),
      .req_downstream_ready (req_downstream_ready),
      .cmd                  (cmd),
      .status               (status),
      .rsp_handed_back      (rsp_handed_back),
      .rsp_tx_valid         (rsp_tx_valid),
      .rsp_tx_handle        (rsp_tx_handle),
      .rsp_tx_class         (rsp_tx_class),
      .rsp_more_pending     (rsp_more_pending)
   );

endmodule

// ===== sv/wtcq_checker.sv =====
// Port-level assertions for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module wtcq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_action,
   input logic [wtcq_pkg::PRIO_W-1:0]       req_user_priority,
   input logic [wtcq_pkg::HANDLE_W-1:0]     req_packet_handle,
   input logic [wtcq_pkg::NUM_CLASSES-1:0]  req_downstream_ready,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_handed_back,
   input logic                              rsp_tx_valid,
   input logic [wtcq_pkg::HANDLE_W-1:0]     rsp_tx_handle,
   input logic [wtcq_pkg::CLASS_W-1:0]      rsp_tx_class,
   input logic                              rsp_more_pending
);
   import wtcq_pkg::*;

   // offered transaction stays put while stalled
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_action) &&
      $stable(req_user_priority) && $stable(req_packet_handle) &&
      $stable(req_downstream_ready))
      else $error("request changed while stalled");

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_handle) &&
      $stable(rsp_tx_class) && $stable(rsp_handed_back) && $stable(rsp_tx_valid) &&
      $stable(rsp_more_pending))
      else $error("result changed while stalled");

   // one transaction in flight: no accept while a result is shown
   a_single_issue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // accepted transaction cannot produce a result in the next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result too early");

   // pop and hand-back are exclusive; an empty pop reports nothing
   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tx_valid && rsp_handed_back) &&
      (rsp_tx_valid || (rsp_tx_handle == '0 && !rsp_more_pending)))
      else $error("inconsistent result fields");

endmodule

bind wmm_tx_class_queue_scheduler wtcq_checker u_wtcq_checker (.*);
